// ----- hdl/line_follow_pid_differential_drive_macros.svh -----
// assertion macros for the line follower pid block
`ifndef LINE_FOLLOW_PID_DIFFERENTIAL_DRIVE_MACROS_SVH
`define LINE_FOLLOW_PID_DIFFERENTIAL_DRIVE_MACROS_SVH

// same-cycle implication, checked on clk outside of rst
`define LFPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk outside of rst
`define LFPD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/lfpd_pkg.sv -----
// types and constants shared by the line follower pid block
`timescale 1ns / 1ps

package lfpd_pkg;

  localparam int POS_W  = 13;
  localparam int GAIN_W = 16;
  localparam int ERR_W  = 14;
  localparam int DIFF_W = 15;
  localparam int SUM_W  = 24;
  localparam int DUTY_W = 8;
  localparam int IDX_W  = 3;
  localparam int PROP_P_W  = GAIN_W + ERR_W;
  localparam int DERIV_P_W = GAIN_W + DIFF_W;
  localparam int INTEG_P_W = GAIN_W + SUM_W;
  localparam int ACC_W  = INTEG_P_W + 2;
  localparam int FRAC_W = 8;
  localparam int ADJ_W  = ACC_W - FRAC_W;

  localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST  = 16'sd1444;
  localparam logic signed [GAIN_W-1:0] DERIV_GAIN_RST = 16'sd18;
  localparam logic signed [GAIN_W-1:0] INTEG_GAIN_RST = 16'sd67;
  localparam logic [POS_W-1:0]         TARGET_RST     = 13'd3500;
  localparam logic [DUTY_W-1:0]        TOP_SPEED_RST  = 8'd150;

  localparam logic [FRAC_W-1:0] TRUNC_BIAS = '1;

  typedef enum logic [IDX_W-1:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_DERIV_GAIN = 3'd1,
    REG_INTEG_GAIN = 3'd2,
    REG_TARGET     = 3'd3,
    REG_TOP_SPEED  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] prop;
    logic signed [GAIN_W-1:0] deriv;
    logic signed [GAIN_W-1:0] integ;
  } gains_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic signed [DIFF_W-1:0] diff;
    logic signed [SUM_W-1:0]  sum;
  } err_word_t;

endpackage

// ----- hdl/lfpd_mac.sv -----
// gain multiplies, q.8 sum and truncation toward zero
`timescale 1ns / 1ps

module lfpd_mac (
  input  logic                                  clk,
  input  logic                                  rst,
  input  lfpd_pkg::gains_t                      gains,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  lfpd_pkg::err_word_t                   in_word,
  output logic                                  adj_valid,
  input  logic                                  adj_ready,
  output logic signed [lfpd_pkg::ADJ_W-1:0]     adj
);

  logic                                        p_valid;
  logic                                        p_ready;
  logic signed [lfpd_pkg::PROP_P_W-1:0]        p_prop;
  logic signed [lfpd_pkg::DERIV_P_W-1:0]       p_deriv;
  logic signed [lfpd_pkg::INTEG_P_W-1:0]       p_integ;
  logic                                        a_ready;
  logic signed [lfpd_pkg::ACC_W-1:0]           acc;
  logic signed [lfpd_pkg::ACC_W-1:0]           acc_biased;

  assign a_ready  = !adj_valid || adj_ready;
  assign p_ready  = !p_valid || a_ready;
  assign in_ready = p_ready;

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_ready) begin
      p_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p_ready && in_valid) begin
      p_prop  <= lfpd_pkg::PROP_P_W'(gains.prop) * lfpd_pkg::PROP_P_W'(in_word.err);
      p_deriv <= lfpd_pkg::DERIV_P_W'(gains.deriv) * lfpd_pkg::DERIV_P_W'(in_word.diff);
      p_integ <= lfpd_pkg::INTEG_P_W'(gains.integ) * lfpd_pkg::INTEG_P_W'(in_word.sum);
    end
  end

  // exact sum, then bias negatives so the shift truncates toward zero
  always_comb begin
    acc = lfpd_pkg::ACC_W'(p_prop) + lfpd_pkg::ACC_W'(p_deriv)
        + lfpd_pkg::ACC_W'(p_integ);
    acc_biased = acc[lfpd_pkg::ACC_W-1]
               ? acc + lfpd_pkg::ACC_W'(lfpd_pkg::TRUNC_BIAS)
               : acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      adj_valid <= 1'b0;
    end else if (a_ready) begin
      adj_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && p_valid) begin
      adj <= acc_biased[lfpd_pkg::ACC_W-1:lfpd_pkg::FRAC_W];
    end
  end

endmodule

// ----- hdl/line_follow_pid_differential_drive.sv -----
// top level of the line follower pid controller with differential drive outputs
// usage:
//   one line_position word enters on the in_valid / in_ready channel per sample
//   each word yields exactly one (left_drive, right_drive) word on out_valid / out_ready
//   gains, target and top speed are written through cfg_we / cfg_index / cfg_data
//   while the block is idle; writes to unused indexes are ignored
// timing:
//   four register stages: error and integral, gain products, adjustment, drives
//   one word per cycle sustained while out_ready stays high; each stage holds its own valid bit
// reset:
//   rst (synchronous) empties the pipeline, zeroes the integral and the
//   previous error, and reloads every configuration register with its default
// stalls:
//   a stage holds while the stage after it is full and blocked, so with
//   out_ready low the block still takes words until all stages are full;
//   then in_ready drops
`timescale 1ns / 1ps

module line_follow_pid_differential_drive (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [lfpd_pkg::IDX_W-1:0]     cfg_index,
  input  logic [lfpd_pkg::GAIN_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [lfpd_pkg::POS_W-1:0]     line_position,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [lfpd_pkg::DUTY_W-1:0]    left_drive,
  output logic [lfpd_pkg::DUTY_W-1:0]    right_drive
);

  localparam int WIDE_W = lfpd_pkg::ADJ_W + 1;

  // configuration registers
  lfpd_pkg::gains_t                    gains;
  logic [lfpd_pkg::POS_W-1:0]          target_position;
  logic [lfpd_pkg::DUTY_W-1:0]         top_speed;

  // controller state
  logic signed [lfpd_pkg::SUM_W-1:0]   error_sum;
  logic signed [lfpd_pkg::ERR_W-1:0]   prior_error;

  // first stage
  logic                                s1_valid;
  logic                                s1_ready;
  lfpd_pkg::err_word_t                 s1_word;
  lfpd_pkg::err_word_t                 s1_word_next;
  logic signed [lfpd_pkg::ERR_W-1:0]   err;
  logic signed [lfpd_pkg::SUM_W:0]     sum_wide;
  logic signed [lfpd_pkg::SUM_W-1:0]   error_sum_next;

  // mac to drive stage
  logic                                mac_ready;
  logic                                adj_valid;
  logic                                adj_ready;
  logic signed [lfpd_pkg::ADJ_W-1:0]   adj;

  // drive clamp
  logic signed [WIDE_W-1:0]            top_wide;
  logic signed [WIDE_W-1:0]            left_wide;
  logic signed [WIDE_W-1:0]            right_wide;
  logic [lfpd_pkg::DUTY_W-1:0]         left_next;
  logic [lfpd_pkg::DUTY_W-1:0]         right_next;

  logic                                in_take;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gains.prop      <= lfpd_pkg::PROP_GAIN_RST;
      gains.deriv     <= lfpd_pkg::DERIV_GAIN_RST;
      gains.integ     <= lfpd_pkg::INTEG_GAIN_RST;
      target_position <= lfpd_pkg::TARGET_RST;
      top_speed       <= lfpd_pkg::TOP_SPEED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lfpd_pkg::REG_PROP_GAIN:  gains.prop      <= cfg_data;
        lfpd_pkg::REG_DERIV_GAIN: gains.deriv     <= cfg_data;
        lfpd_pkg::REG_INTEG_GAIN: gains.integ     <= cfg_data;
        lfpd_pkg::REG_TARGET:     target_position <= cfg_data[lfpd_pkg::POS_W-1:0];
        lfpd_pkg::REG_TOP_SPEED:  top_speed       <= cfg_data[lfpd_pkg::DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // error, saturating integral and error difference
  always_comb begin
    err = $signed({1'b0, target_position}) - $signed({1'b0, line_position});
    sum_wide = (lfpd_pkg::SUM_W + 1)'(error_sum) + (lfpd_pkg::SUM_W + 1)'(err);
    // top two bits disagree on overflow: pin to the rail on the sign side
    if (sum_wide[lfpd_pkg::SUM_W] != sum_wide[lfpd_pkg::SUM_W-1]) begin
      error_sum_next = {sum_wide[lfpd_pkg::SUM_W],
                        {(lfpd_pkg::SUM_W-1){!sum_wide[lfpd_pkg::SUM_W]}}};
    end else begin
      error_sum_next = sum_wide[lfpd_pkg::SUM_W-1:0];
    end
    s1_word_next.err  = err;
    s1_word_next.diff = lfpd_pkg::DIFF_W'(err) - lfpd_pkg::DIFF_W'(prior_error);
    s1_word_next.sum  = error_sum_next;
  end

  assign s1_ready = !s1_valid || mac_ready;
  assign in_ready = s1_ready;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      error_sum   <= '0;
      prior_error <= '0;
    end else begin
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
      // state follows accepted words in order
      if (in_take) begin
        error_sum   <= error_sum_next;
        prior_error <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_word <= s1_word_next;
    end
  end

  // products and truncated adjustment
  lfpd_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .gains     (gains),
    .in_valid  (s1_valid),
    .in_ready  (mac_ready),
    .in_word   (s1_word),
    .adj_valid (adj_valid),
    .adj_ready (adj_ready),
    .adj       (adj)
  );

  // clamp both drives into 0 .. top_speed
  always_comb begin
    top_wide   = $signed({{(WIDE_W - lfpd_pkg::DUTY_W){1'b0}}, top_speed});
    left_wide  = top_wide - WIDE_W'(adj);
    right_wide = top_wide + WIDE_W'(adj);
    if (left_wide[WIDE_W-1]) begin
      left_next = '0;
    end else if (left_wide > top_wide) begin
      left_next = top_speed;
    end else begin
      left_next = left_wide[lfpd_pkg::DUTY_W-1:0];
    end
    if (right_wide[WIDE_W-1]) begin
      right_next = '0;
    end else if (right_wide > top_wide) begin
      right_next = top_speed;
    end else begin
      right_next = right_wide[lfpd_pkg::DUTY_W-1:0];
    end
  end

  // output register
  assign adj_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adj_ready) begin
      out_valid <= adj_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adj_ready && adj_valid) begin
      left_drive  <= left_next;
      right_drive <= right_next;
    end
  end

  // checks
  logic [lfpd_pkg::DUTY_W:0] drive_sum;
  logic [lfpd_pkg::DUTY_W:0] top_twice;
  logic                      both_inside;
  logic                      drives_capped;
  logic                      balance_due;
  logic                      drives_even;

  assign drive_sum   = {1'b0, left_drive} + {1'b0, right_drive};
  assign top_twice   = {top_speed, 1'b0};
  assign both_inside = (left_drive != '0) && (left_drive != top_speed)
                    && (right_drive != '0) && (right_drive != top_speed);
  assign drives_capped = (left_drive <= top_speed) && (right_drive <= top_speed);
  assign balance_due   = out_valid && both_inside;
  assign drives_even   = drive_sum == top_twice;

`include "line_follow_pid_differential_drive_macros.svh"

  `LFPD_ASSERT_IMP(a_drive_in_range, out_valid, drives_capped, "drive above top speed")
  `LFPD_ASSERT_IMP(a_drive_balance, balance_due, drives_even, "unclamped drives not symmetric")
  `LFPD_ASSERT_NXT(a_prior_error_tracks, in_take, prior_error == $past(err), "previous error not updated")
  `LFPD_ASSERT_IMP(a_full_blocks_input, s1_valid && !mac_ready, !in_ready, "input taken over a full stage")

endmodule

// ----- tb/sv/line_follow_pid_differential_drive_tb.sv -----
// self-checking testbench for the line follower pid block with a drive scoreboard
`timescale 1ns / 1ps

module line_follow_pid_differential_drive_tb;

  localparam int CLK_HALF = 5;

  // register defaults after reset, kept independent of the package
  localparam logic signed [lfpd_pkg::GAIN_W-1:0] KP_DEFAULT = 16'sd1444;
  localparam logic signed [lfpd_pkg::GAIN_W-1:0] KD_DEFAULT = 16'sd18;
  localparam logic signed [lfpd_pkg::GAIN_W-1:0] KI_DEFAULT = 16'sd67;
  localparam logic [lfpd_pkg::POS_W-1:0]         TARGET_DEFAULT = 13'd3500;
  localparam logic [lfpd_pkg::DUTY_W-1:0]        TOP_DEFAULT = 8'd150;

  // an index with no register behind it, writes there must change nothing
  localparam logic [lfpd_pkg::IDX_W-1:0] REG_SPARE = 3'd7;

  // integral bounds, signed 24 bit
  localparam longint SUM_HI = 8388607;
  localparam longint SUM_LO = -8388608;

  localparam logic [lfpd_pkg::POS_W-1:0] POS_MAX = 13'h1fff;

  localparam int PRE_SAMPLES   = 400;
  localparam int WINDUP_CAP    = 1400;
  localparam int WINDUP_HOLD   = 30;
  localparam int POST_SAMPLES  = 110;
  localparam int HOLD_CYCLES   = 100;
  localparam int HOLD_AFTER    = 120;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int MAX_REPORTS   = 10;

  // positions for the first sample words under the reset settings
  localparam int RESET_POS [12] = '{0, 7000, 3500, 8191, 1, 4096, 2048, 6999, 3501, 5461,
                                    2730, 8190};

  typedef struct packed {
    logic [lfpd_pkg::DUTY_W-1:0] l_duty;
    logic [lfpd_pkg::DUTY_W-1:0] r_duty;
  } drive_pair_t;

  typedef enum int {POS_FULL, POS_NOMINAL, POS_NEAR} pos_mode_t;

  // pid predictor plus the queue of drive words it expects
  class drive_scoreboard;
    logic signed [lfpd_pkg::GAIN_W-1:0] kp, kd, ki;
    logic [lfpd_pkg::POS_W-1:0]         target;
    logic [lfpd_pkg::DUTY_W-1:0]        top;
    logic signed [lfpd_pkg::SUM_W-1:0]  err_sum;
    logic signed [lfpd_pkg::ERR_W-1:0]  prev_err;
    drive_pair_t                        drive_q[$];
    int unsigned                        samples, checked, mismatches, sat_hits;

    function new();
      kp = KP_DEFAULT;
      kd = KD_DEFAULT;
      ki = KI_DEFAULT;
      target = TARGET_DEFAULT;
      top = TOP_DEFAULT;
      err_sum = '0;
      prev_err = '0;
      samples = 0;
      checked = 0;
      mismatches = 0;
      sat_hits = 0;
    endfunction

    function void set_reg(logic [lfpd_pkg::IDX_W-1:0] idx, logic [lfpd_pkg::GAIN_W-1:0] d);
      case (idx)
        lfpd_pkg::REG_PROP_GAIN:  kp = d;
        lfpd_pkg::REG_DERIV_GAIN: kd = d;
        lfpd_pkg::REG_INTEG_GAIN: ki = d;
        lfpd_pkg::REG_TARGET:     target = d[lfpd_pkg::POS_W-1:0];
        lfpd_pkg::REG_TOP_SPEED:  top = d[lfpd_pkg::DUTY_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [lfpd_pkg::DUTY_W-1:0] clamp_duty(longint v, longint t);
      if (v < 0) return '0;
      if (v > t) return t[lfpd_pkg::DUTY_W-1:0];
      return v[lfpd_pkg::DUTY_W-1:0];
    endfunction

    function void note_sample(logic [lfpd_pkg::POS_W-1:0] pos);
      longint e, s, acc, adj, t;
      drive_pair_t d;
      e = longint'(target) - longint'(pos);
      s = longint'(err_sum) + e;
      if (s > SUM_HI) s = SUM_HI;
      else if (s < SUM_LO) s = SUM_LO;
      if (s == SUM_HI) sat_hits++;
      acc = longint'(kp) * e + longint'(kd) * (e - longint'(prev_err)) + longint'(ki) * s;
      adj = (acc < 0) ? -((-acc) >>> lfpd_pkg::FRAC_W) : (acc >>> lfpd_pkg::FRAC_W);
      err_sum = s[lfpd_pkg::SUM_W-1:0];
      prev_err = e[lfpd_pkg::ERR_W-1:0];
      t = longint'(top);
      d.l_duty = clamp_duty(t - adj, t);
      d.r_duty = clamp_duty(t + adj, t);
      drive_q.push_back(d);
      samples++;
    endfunction

    function void check_drives(logic [lfpd_pkg::DUTY_W-1:0] l_got,
                               logic [lfpd_pkg::DUTY_W-1:0] r_got);
      drive_pair_t d;
      checked++;
      if (drive_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: drive word left=%0d right=%0d with nothing pending",
                   $time, l_got, r_got);
        return;
      end
      d = drive_q.pop_front();
      if (l_got !== d.l_duty || r_got !== d.r_duty) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: drive word %0d: expected left=%0d right=%0d, got left=%0d right=%0d",
                   $time, checked, d.l_duty, d.r_duty, l_got, r_got);
      end
    endfunction

    function void flush_leftover();
      if (drive_q.size() != 0) begin
        $display("%0d drive words never arrived", drive_q.size());
        mismatches += drive_q.size();
      end
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_we = 1'b0;
  logic [lfpd_pkg::IDX_W-1:0]  cfg_index = '0;
  logic [lfpd_pkg::GAIN_W-1:0] cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [lfpd_pkg::POS_W-1:0]  line_position = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [lfpd_pkg::DUTY_W-1:0] left_drive;
  logic [lfpd_pkg::DUTY_W-1:0] right_drive;

  drive_scoreboard sb;
  bit              src_steady = 1'b0;
  int unsigned     settings_used = 0;
  int unsigned     in_stall_cycles = 0;

  line_follow_pid_differential_drive u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .line_position (line_position),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .left_drive    (left_drive),
    .right_drive   (right_drive)
  );

  always #CLK_HALF clk = ~clk;

  // idle length: mostly none or short, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // gains: the two extremes, full random, and small values that keep drives off the rails
  function automatic logic [lfpd_pkg::GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2, 3: return 16'($urandom);
      4, 5: return 16'(int'($urandom_range(0, 128)) - 64);
      default: return 16'(int'($urandom_range(0, 1200)) - 600);
    endcase
  endfunction

  function automatic logic [lfpd_pkg::POS_W-1:0] pick_target();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 13'd7000;
      2: return POS_MAX;
      3: return 13'($urandom);
      default: return 13'($urandom_range(0, 7000));
    endcase
  endfunction

  function automatic logic [lfpd_pkg::DUTY_W-1:0] pick_top();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [lfpd_pkg::POS_W-1:0] pick_pos(pos_mode_t m);
    int p;
    case (m)
      POS_FULL:    p = $urandom_range(0, 8191);
      POS_NOMINAL: p = $urandom_range(0, 7000);
      default:     p = int'(sb.target) + int'($urandom_range(0, 400)) - 200;
    endcase
    if (p < 0) p = 0;
    if (p > 8191) p = 8191;
    return p[lfpd_pkg::POS_W-1:0];
  endfunction

  // one register write, then a quiet edge so cfg_we never toggles twice in a step
  task automatic write_reg(logic [lfpd_pkg::IDX_W-1:0] idx, logic [lfpd_pkg::GAIN_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, d);
    @(posedge clk);
  endtask

  // full register set; unused upper data bits carry junk to check the masking
  task automatic apply_setting(logic [lfpd_pkg::GAIN_W-1:0] p, logic [lfpd_pkg::GAIN_W-1:0] d,
                               logic [lfpd_pkg::GAIN_W-1:0] i, logic [lfpd_pkg::POS_W-1:0] tgt,
                               logic [lfpd_pkg::DUTY_W-1:0] spd);
    write_reg(lfpd_pkg::REG_PROP_GAIN, p);
    write_reg(lfpd_pkg::REG_DERIV_GAIN, d);
    write_reg(lfpd_pkg::REG_INTEG_GAIN, i);
    write_reg(lfpd_pkg::REG_TARGET, {3'($urandom), tgt});
    write_reg(lfpd_pkg::REG_TOP_SPEED, {8'($urandom), spd});
    settings_used++;
  endtask

  task automatic random_setting();
    apply_setting(pick_gain(), pick_gain(), pick_gain(), pick_target(), pick_top());
    if ($urandom_range(0, 4) == 0) write_reg(REG_SPARE, 16'($urandom));
  endtask

  // offer one position word; valid stays up across words when there is no gap
  task automatic send_one(logic [lfpd_pkg::POS_W-1:0] pos);
    int g;
    g = src_steady ? 0 : idle_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    line_position <= pos;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(pos);
  endtask

  // block idle: input dropped, every drive word back, then a settle wait to cover the pipe depth
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.drive_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // receiving side: checks drive words, random stalls, one long hold-off
  initial begin : drive_sink
    int stall_left;
    int hold_left;
    bit hold_done;
    bit sink_steady;
    stall_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    sink_steady = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (in_valid && !in_ready) in_stall_cycles++;
        if (out_valid && out_ready) begin
          sb.check_drives(left_drive, right_drive);
          // now and then a stretch with the sink always ready
          if (sb.checked % 100 == 0) sink_steady = ($urandom_range(0, 3) == 0);
        end
        // long hold-off while the sender keeps offering, so the pipe fills up
        if (!hold_done && sb.checked >= HOLD_AFTER && in_valid) begin
          hold_done = 1'b1;
          hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
          hold_left--;
          out_ready <= 1'b0;
        end else if (stall_left > 0) begin
          stall_left--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
          if (!sink_steady && $urandom_range(0, 2) == 0) stall_left = idle_len();
        end
      end
    end
  end

  initial begin : watchdog
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int n;
    int goal;
    int start_hits;
    pos_mode_t mode;
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings untouched: first sample sees a zero previous error,
    // positions at both ends, the center and beyond the nominal range
    src_steady = 1'b0;
    foreach (RESET_POS[k]) send_one(RESET_POS[k][lfpd_pkg::POS_W-1:0]);
    wait_idle();

    // gain extremes, target zero, full speed: drives mostly pinned at the rails
    apply_setting(16'h7fff, 16'h8000, 16'h0000, 13'd0, 8'hff);
    send_one(13'd0);
    send_one(POS_MAX);
    send_one(13'd4000);
    send_one(13'd0);
    wait_idle();

    // opposite extremes, target at the 13-bit top, zero speed gives zero drives
    write_reg(REG_SPARE, 16'hffff);
    apply_setting(16'h8000, 16'h7fff, 16'h8000, POS_MAX, 8'd0);
    send_one(POS_MAX);
    send_one(13'd0);
    send_one(13'd100);
    wait_idle();

    // unity proportional gain only: adjustment equals the error, one drive drops by it, the other stays at top speed
    apply_setting(16'sd256, 16'sd0, 16'sd0, 13'd3500, 8'd128);
    send_one(13'd3500);
    send_one(13'd3400);
    send_one(13'd3600);
    wait_idle();

    // random settings, random positions
    goal = sb.samples + PRE_SAMPLES;
    while (sb.samples < goal) begin
      random_setting();
      mode = pos_mode_t'($urandom_range(0, 2));
      src_steady = ($urandom_range(0, 3) == 0);
      n = $urandom_range(20, 60);
      repeat (n) send_one(pick_pos(mode));
      wait_idle();
    end

    // drive the integral into its upper bound and keep it there a while;
    // kp of -4 cancels ki*sum near the bound so the saturated value shows in the drives
    apply_setting(16'hfc00, 16'h0000, 16'h0001, POS_MAX, 8'd128);
    src_steady = 1'b0;
    start_hits = sb.sat_hits;
    n = 0;
    while (sb.sat_hits - start_hits < WINDUP_HOLD && n < WINDUP_CAP) begin
      send_one(($urandom_range(0, 3) == 0) ? 13'($urandom_range(0, 15)) : 13'd0);
      n++;
    end
    wait_idle();

    // random again, coming off the bound; integral gain often zero so drives move
    goal = sb.samples + POST_SAMPLES;
    while (sb.samples < goal) begin
      random_setting();
      if ($urandom_range(0, 1) == 0) write_reg(lfpd_pkg::REG_INTEG_GAIN, 16'h0000);
      mode = pos_mode_t'($urandom_range(0, 2));
      src_steady = ($urandom_range(0, 3) == 0);
      n = $urandom_range(15, 40);
      repeat (n) send_one(pick_pos(mode));
      wait_idle();
    end

    // bounded drain, then settle
    n = 0;
    while (sb.drive_q.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (8) @(posedge clk);
    sb.flush_leftover();

    $display("covered %0d position words and %0d drive words over %0d register settings",
             sb.samples, sb.checked, settings_used);
    $display("integral at its upper bound on %0d words, input held back on %0d cycles",
             sb.sat_hits, in_stall_cycles);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d drive mismatches", sb.mismatches);
      $display("status: fail");
    end
    $finish;
  end

endmodule
